@@ design/fbc_pkg.sv @@
`default_nettype none

package fbc_pkg;

  // defaults for the top level parameters
  localparam int unsigned PlaneCountDef = 6;
  localparam int unsigned CoordBitsDef  = 32;

  // fixed port widths
  localparam int unsigned FieldW  = 32;
  localparam int unsigned PIdxW   = 3;
  // Q16.16 offset is moved up to the Q32.32 product scale
  localparam int unsigned FracBits = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             load;       // write one plane from the input ports
    logic             capture;    // latch the box corners, set the visible flag
    logic             mul_en;     // form the three products of one plane
    logic [PIdxW-1:0] plane_idx;  // plane fed to the products
    logic             sum_en;     // add up the registered products, fold the sign
  } fbc_cmd_t;

endpackage

`default_nettype wire

@@ design/fbc_ctrl.sv @@
`default_nettype none

module fbc_ctrl
  import fbc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = PlaneCountDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire logic     op_i,
  output fbc_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  localparam int unsigned IdxW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PLANE_COUNT - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic            take;

  assign take = start_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (take && (op_e'(op_i) == OP_TEST)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.plane_idx = PIdxW'(cnt_q);
    done_d          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load    = take && (op_e'(op_i) == OP_LOAD);
        cmd_o.capture = take && (op_e'(op_i) == OP_TEST);
      end
      ST_RUN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.sum_en = (cnt_q != '0);
      end
      ST_DRAIN: begin
        cmd_o.sum_en = 1'b1;
        done_d       = 1'b1;
      end
      default: begin
        cmd_o.sum_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ design/fbc_dp.sv @@
`default_nettype none

module fbc_dp
  import fbc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = PlaneCountDef,
  parameter int unsigned COORD_BITS  = CoordBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fbc_cmd_t          cmd_i,
  input  wire logic [PIdxW-1:0]  plane_index_i,
  input  wire logic [FieldW-1:0] normal_x_i,
  input  wire logic [FieldW-1:0] normal_y_i,
  input  wire logic [FieldW-1:0] normal_z_i,
  input  wire logic [FieldW-1:0] plane_offset_i,
  input  wire logic [FieldW-1:0] min_x_i,
  input  wire logic [FieldW-1:0] min_y_i,
  input  wire logic [FieldW-1:0] min_z_i,
  input  wire logic [FieldW-1:0] max_x_i,
  input  wire logic [FieldW-1:0] max_y_i,
  input  wire logic [FieldW-1:0] max_z_i,
  output logic                   visible_o
);

  localparam int unsigned IdxW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int unsigned ProdW = 2 * COORD_BITS;
  localparam int unsigned SumW  = 2 * COORD_BITS + 3;

  // plane store, written only by loads
  logic signed [COORD_BITS-1:0] nx_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] ny_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] nz_q [PLANE_COUNT];
  logic signed [COORD_BITS-1:0] d_q  [PLANE_COUNT];

  logic signed [COORD_BITS-1:0] mnx_q, mny_q, mnz_q, mxx_q, mxy_q, mxz_q;

  logic signed [COORD_BITS-1:0] nx, ny, nz, px, py, pz;
  logic [IdxW-1:0]              rd_idx;
  logic                         wr_ok;

  logic signed [ProdW-1:0]      prx_q, pry_q, prz_q;
  logic signed [COORD_BITS-1:0] dd_q;
  logic signed [SumW-1:0]       sum;
  logic                         vis_q, vis_d;

  assign wr_ok = ({1'b0, plane_index_i} < (PIdxW + 1)'(PLANE_COUNT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      nx_q[plane_index_i[IdxW-1:0]] <= normal_x_i[COORD_BITS-1:0];
      ny_q[plane_index_i[IdxW-1:0]] <= normal_y_i[COORD_BITS-1:0];
      nz_q[plane_index_i[IdxW-1:0]] <= normal_z_i[COORD_BITS-1:0];
      d_q[plane_index_i[IdxW-1:0]]  <= plane_offset_i[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mnx_q <= min_x_i[COORD_BITS-1:0];
      mny_q <= min_y_i[COORD_BITS-1:0];
      mnz_q <= min_z_i[COORD_BITS-1:0];
      mxx_q <= max_x_i[COORD_BITS-1:0];
      mxy_q <= max_y_i[COORD_BITS-1:0];
      mxz_q <= max_z_i[COORD_BITS-1:0];
    end
  end

  // pick the corner farthest along the normal
  assign rd_idx = cmd_i.plane_idx[IdxW-1:0];
  assign nx     = nx_q[rd_idx];
  assign ny     = ny_q[rd_idx];
  assign nz     = nz_q[rd_idx];
  assign px     = nx[COORD_BITS-1] ? mnx_q : mxx_q;
  assign py     = ny[COORD_BITS-1] ? mny_q : mxy_q;
  assign pz     = nz[COORD_BITS-1] ? mnz_q : mxz_q;

  // exact products, registered before the sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prx_q <= ProdW'(nx) * ProdW'(px);
      pry_q <= ProdW'(ny) * ProdW'(py);
      prz_q <= ProdW'(nz) * ProdW'(pz);
      dd_q  <= d_q[rd_idx];
    end
  end

  assign sum = SumW'(prx_q) + SumW'(pry_q) + SumW'(prz_q)
             + (SumW'(dd_q) <<< FracBits);

  always_comb begin
    vis_d = vis_q;
    if (cmd_i.capture) begin
      vis_d = 1'b1;
    end else if (cmd_i.sum_en) begin
      vis_d = vis_q & ~sum[SumW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= 1'b1;
    end else begin
      vis_q <= vis_d;
    end
  end

  assign visible_o = vis_q;

endmodule

`default_nettype wire

@@ design/frustum_box_cull_test.sv @@
// channel   | ports                                         | transaction
// ----------+-----------------------------------------------+---------------------------------
// command   | start_i, busy_o, op_i, plane_index_i, normal_*| edge with start_i high, busy_o low
//           | _i, plane_offset_i, min_*_i, max_*_i          |
// result    | done_o, visible_o                             | edge ending the cycle done_o is high
//
// a plane load never raises busy_o; it gives no result
// a box test holds busy_o while one plane per cycle goes
// through the shared three-multiplier dot unit, then while a drain state sums the last one
// done_o pulses, registered, once the drain state ends, in a cycle where
// the next command may already be taken
// reset is asynchronous, active low; the plane store has no reset
// the receiver cannot stall: visible_o is valid only while done_o is high
`default_nettype none

module frustum_box_cull_test
  import fbc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = PlaneCountDef,
  parameter int unsigned COORD_BITS  = CoordBitsDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command side
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              op_i,
  input  wire logic [PIdxW-1:0]  plane_index_i,
  input  wire logic [FieldW-1:0] normal_x_i,
  input  wire logic [FieldW-1:0] normal_y_i,
  input  wire logic [FieldW-1:0] normal_z_i,
  input  wire logic [FieldW-1:0] plane_offset_i,
  input  wire logic [FieldW-1:0] min_x_i,
  input  wire logic [FieldW-1:0] min_y_i,
  input  wire logic [FieldW-1:0] min_z_i,
  input  wire logic [FieldW-1:0] max_x_i,
  input  wire logic [FieldW-1:0] max_y_i,
  input  wire logic [FieldW-1:0] max_z_i,
  // result side
  output logic                   done_o,
  output logic                   visible_o
);

  // command bundle from the sequencer to the datapath
  fbc_cmd_t cmd;

  // sequencer: walks the planes of a test, issues loads
  fbc_ctrl #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // datapath: plane store, corner select, products, sum and sign fold
  fbc_dp #(
    .PLANE_COUNT (PLANE_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .plane_index_i  (plane_index_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .visible_o      (visible_o)
  );

endmodule

`default_nettype wire

@@ verif/frustum_box_cull_test_test.sv @@
`timescale 1ns / 1ps

module frustum_box_cull_test_test
  import fbc_pkg::*;
;

  // a stall in which no transaction moves on either side for this long ends the run
  localparam int unsigned WatchdogLimit = 1000;
  // items per random phase, three phases with different sender idling
  localparam int unsigned PhaseItems = 380;
  // extra wait after the last owed result, for a late done_o to show
  localparam int unsigned DrainCycles = PlaneCountDef + 4;

  // one command as it sits on the input ports
  typedef struct {
    op_e              op;
    logic [PIdxW-1:0] idx;
    logic [FieldW-1:0] nx, ny, nz, off;
    logic [FieldW-1:0] mnx, mny, mnz, mxx, mxy, mxz;
  } cull_cmd_t;

  // keeps its own copy of the plane store and the visible flags still owed
  class cull_scoreboard;
    logic signed [FieldW-1:0] plane_nx  [PlaneCountDef];
    logic signed [FieldW-1:0] plane_ny  [PlaneCountDef];
    logic signed [FieldW-1:0] plane_nz  [PlaneCountDef];
    logic signed [FieldW-1:0] plane_off [PlaneCountDef];
    bit visible_owed[$];
    int errors;
    int loads_taken;
    int loads_dropped;
    int boxes_visible;
    int boxes_culled;

    // p-vertex test against every plane, exact 128-bit sums
    function bit box_visible(cull_cmd_t c);
      longint nx, ny, nz, px, py, pz, dd;
      logic signed [127:0] acc;
      for (int i = 0; i < PlaneCountDef; i++) begin
        nx = 64'(plane_nx[i]);
        ny = 64'(plane_ny[i]);
        nz = 64'(plane_nz[i]);
        dd = 64'(plane_off[i]);
        px = (nx >= 0) ? 64'($signed(c.mxx)) : 64'($signed(c.mnx));
        py = (ny >= 0) ? 64'($signed(c.mxy)) : 64'($signed(c.mny));
        pz = (nz >= 0) ? 64'($signed(c.mxz)) : 64'($signed(c.mnz));
        // products land in q32.32, the offset is moved up by 16 bits
        acc = 128'(nx * px) + 128'(ny * py) + 128'(nz * pz) + 128'(dd * 65536);
        if (acc < 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_command(cull_cmd_t c);
      bit v;
      if (c.op == OP_LOAD) begin
        if (c.idx < PlaneCountDef) begin
          plane_nx[c.idx]  = c.nx;
          plane_ny[c.idx]  = c.ny;
          plane_nz[c.idx]  = c.nz;
          plane_off[c.idx] = c.off;
          loads_taken++;
        end else begin
          loads_dropped++;
        end
      end else begin
        v = box_visible(c);
        visible_owed.push_back(v);
        if (v) boxes_visible++;
        else boxes_culled++;
      end
    endfunction

    function void check_visible(logic got);
      bit want;
      if (visible_owed.size() == 0) begin
        $display("%0t: visible result %b with no test outstanding", $time, got);
        errors++;
        return;
      end
      want = visible_owed.pop_front();
      if (got !== want) begin
        $display("%0t: visible mismatch, expected %b, actual %b", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return visible_owed.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              op_i;
  logic [PIdxW-1:0]  plane_index_i;
  logic [FieldW-1:0] normal_x_i, normal_y_i, normal_z_i, plane_offset_i;
  logic [FieldW-1:0] min_x_i, min_y_i, min_z_i, max_x_i, max_y_i, max_z_i;
  logic              done_o;
  logic              visible_o;

  cull_scoreboard sb = new();
  cull_cmd_t      seen_cmd;
  int unsigned    idle_pct;
  int unsigned    stall_cycles;

  frustum_box_cull_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .plane_index_i  (plane_index_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .min_x_i        (min_x_i),
    .min_y_i        (min_y_i),
    .min_z_i        (min_z_i),
    .max_x_i        (max_x_i),
    .max_y_i        (max_y_i),
    .max_z_i        (max_z_i),
    .done_o         (done_o),
    .visible_o      (visible_o)
  );

  always #5 clk_i = ~clk_i;

  // whole units to q16.16
  function automatic logic [FieldW-1:0] fx(int whole);
    return FieldW'(whole * 65536);
  endfunction

  // uniform in [-span, span], raw q16.16
  function automatic logic [FieldW-1:0] around_zero(int unsigned span);
    return FieldW'($urandom_range(0, 2 * span)) - FieldW'(span);
  endfunction

  // every field random, so the ignored fields of each kind toggle too
  function automatic cull_cmd_t noise_command();
    cull_cmd_t c;
    c.op  = $urandom_range(0, 1) ? OP_TEST : OP_LOAD;
    c.idx = PIdxW'($urandom_range(0, 7));
    c.nx  = $urandom();
    c.ny  = $urandom();
    c.nz  = $urandom();
    c.off = $urandom();
    c.mnx = $urandom();
    c.mny = $urandom();
    c.mnz = $urandom();
    c.mxx = $urandom();
    c.mxy = $urandom();
    c.mxz = $urandom();
    return c;
  endfunction

  // mostly scene-like planes and boxes near the origin so that both outcomes
  // show up often; a tenth of the planes and a tenth of the boxes stay raw
  function automatic cull_cmd_t random_command();
    cull_cmd_t c;
    int unsigned pick;
    logic [FieldW-1:0] cx, cy, cz, hx, hy, hz;
    c = noise_command();
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      c.op  = OP_LOAD;
      c.idx = ($urandom_range(0, 9) == 0) ? PIdxW'($urandom_range(PlaneCountDef, 7))
                                          : PIdxW'($urandom_range(0, PlaneCountDef - 1));
      if ($urandom_range(0, 9) != 0) begin
        // normal within +-2.0, offset from -20.0 to 100.0
        c.nx  = around_zero(2 * 65536);
        c.ny  = around_zero(2 * 65536);
        c.nz  = around_zero(2 * 65536);
        c.off = FieldW'($urandom_range(0, 120 * 65536)) - fx(20);
      end
    end else begin
      c.op = OP_TEST;
      pick = $urandom_range(0, 99);
      if (pick < 90) begin
        cx = around_zero(50 * 65536);
        cy = around_zero(50 * 65536);
        cz = around_zero(50 * 65536);
        hx = $urandom_range(0, 20 * 65536);
        hy = $urandom_range(0, 20 * 65536);
        hz = $urandom_range(0, 20 * 65536);
        c.mnx = cx - hx;  c.mny = cy - hy;  c.mnz = cz - hz;
        c.mxx = cx + hx;  c.mxy = cy + hy;  c.mxz = cz + hz;
        // corners swapped, min above max
        if (pick >= 80) begin
          c.mnx = cx + hx;  c.mny = cy + hy;  c.mnz = cz + hz;
          c.mxx = cx - hx;  c.mxy = cy - hy;  c.mxz = cz - hz;
        end
      end
    end
    return c;
  endfunction

  // present one transaction, idling first at the current rate, and hold it
  // until the block takes it; start_i stays high into the next one unless it idles
  task automatic send_command(input cull_cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    op_i           <= c.op;
    plane_index_i  <= c.idx;
    normal_x_i     <= c.nx;
    normal_y_i     <= c.ny;
    normal_z_i     <= c.nz;
    plane_offset_i <= c.off;
    min_x_i        <= c.mnx;
    min_y_i        <= c.mny;
    min_z_i        <= c.mnz;
    max_x_i        <= c.mxx;
    max_y_i        <= c.mxy;
    max_z_i        <= c.mxz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic load_plane(input int unsigned idx, input logic [FieldW-1:0] nx,
                            input logic [FieldW-1:0] ny, input logic [FieldW-1:0] nz,
                            input logic [FieldW-1:0] off);
    cull_cmd_t c;
    c = noise_command();
    c.op  = OP_LOAD;
    c.idx = PIdxW'(idx);
    c.nx  = nx;
    c.ny  = ny;
    c.nz  = nz;
    c.off = off;
    send_command(c);
  endtask

  task automatic test_box(input logic [FieldW-1:0] mnx, input logic [FieldW-1:0] mny,
                          input logic [FieldW-1:0] mnz, input logic [FieldW-1:0] mxx,
                          input logic [FieldW-1:0] mxy, input logic [FieldW-1:0] mxz);
    cull_cmd_t c;
    c = noise_command();
    c.op  = OP_TEST;
    c.mnx = mnx;  c.mny = mny;  c.mnz = mnz;
    c.mxx = mxx;  c.mxy = mxy;  c.mxz = mxz;
    send_command(c);
  endtask

  // monitor: results are checked before the command of the same edge is noted,
  // the result always belongs to an older test
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_visible(visible_o);
      if (start_i && !busy_o) begin
        seen_cmd.op  = op_e'(op_i);
        seen_cmd.idx = plane_index_i;
        seen_cmd.nx  = normal_x_i;
        seen_cmd.ny  = normal_y_i;
        seen_cmd.nz  = normal_z_i;
        seen_cmd.off = plane_offset_i;
        seen_cmd.mnx = min_x_i;
        seen_cmd.mny = min_y_i;
        seen_cmd.mnz = min_z_i;
        seen_cmd.mxx = max_x_i;
        seen_cmd.mxy = max_y_i;
        seen_cmd.mxz = max_z_i;
        sb.note_command(seen_cmd);
      end
    end
  end

  // watchdog on cycles in which no transaction moves
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("frustum_box_cull_test_test: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    cull_cmd_t c;
    stall_cycles   <= 0;
    idle_pct        = 0;
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    op_i           <= OP_LOAD;
    plane_index_i  <= '0;
    normal_x_i     <= '0;
    normal_y_i     <= '0;
    normal_z_i     <= '0;
    plane_offset_i <= '0;
    min_x_i        <= '0;
    min_y_i        <= '0;
    min_z_i        <= '0;
    max_x_i        <= '0;
    max_y_i        <= '0;
    max_z_i        <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // axis-aligned cube of +-10.0: every plane is loaded before any test
    load_plane(0, fx(1),  fx(0),  fx(0),  fx(10));
    load_plane(1, fx(-1), fx(0),  fx(0),  fx(10));
    load_plane(2, fx(0),  fx(1),  fx(0),  fx(10));
    load_plane(3, fx(0),  fx(-1), fx(0),  fx(10));
    load_plane(4, fx(0),  fx(0),  fx(1),  fx(10));
    load_plane(5, fx(0),  fx(0),  fx(-1), fx(10));
    // out-of-range indexes are dropped, store must stay untouched
    load_plane(6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_plane(7, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // inside, fully outside on x, straddling, touching with zero distance
    test_box(fx(0),   fx(0),  fx(0),  fx(1),   fx(1), fx(1));
    test_box(fx(20),  fx(0),  fx(0),  fx(30),  fx(1), fx(1));
    test_box(fx(-15), fx(0),  fx(0),  fx(-5),  fx(1), fx(1));
    test_box(fx(-20), fx(0),  fx(0),  fx(-10), fx(1), fx(1));
    // min above max, corners used as given
    test_box(fx(5), fx(5), fx(5), fx(-5), fx(-5), fx(-5));
    // full-scale normals and offsets against full-scale corners
    load_plane(2, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h7fff_ffff);
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_plane(3, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_box(fx(0), fx(0), fx(0), fx(0), fx(0), fx(0));
    // an all-zero plane never culls, zero normal picks the max corner
    load_plane(4, fx(0), fx(0), fx(0), fx(0));
    test_box(fx(-1), fx(-1), fx(-1), fx(1), fx(1), fx(1));

    // random phases: sender idles seldom, often, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 14 : (phase == 1) ? 52 : 0;
      counted  = 0;
      while (counted < PhaseItems) begin
        c = random_command();
        send_command(c);
        if (!(c.op == OP_LOAD && c.idx >= PlaneCountDef)) counted++;
      end
    end
    start_i <= 1'b0;

    // drain the owed results, then give a late spurious done_o time to show
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d plane loads (%0d dropped for index) and %0d box tests",
             sb.loads_taken, sb.loads_dropped, sb.boxes_visible + sb.boxes_culled);
    $display("box tests: %0d visible, %0d culled, %0d mismatches",
             sb.boxes_visible, sb.boxes_culled, sb.errors);
    if (sb.errors == 0) begin
      $display("frustum_box_cull_test_test: done, clean");
    end else begin
      $display("frustum_box_cull_test_test: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/fbc_pkg.sv
design/fbc_ctrl.sv
design/fbc_dp.sv
design/frustum_box_cull_test.sv
verif/frustum_box_cull_test_test.sv
